### sv/crc32c_pkg.sv
// Package: widths and CRC-32C byte fold functions shared by the engine.
`timescale 1ns / 1ps

package crc32c_pkg;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned CRC_W   = 32;
   localparam int unsigned BYTES   = DATA_W / 8;

   localparam logic [CRC_W-1:0]   POLY_REFLECTED = 32'h82F6_3B78;
   localparam logic [COUNT_W-1:0] MAX_COUNT      = COUNT_W'(BYTES);

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [CRC_W-1:0]   crc_type;

   // One byte through the reflected shift register, LSB first.
   function automatic crc_type fold_byte(input crc_type rem, input logic [7:0] din);
      crc_type r;
      r = rem ^ {24'd0, din};
      for (int b = 0; b < 8; b++) begin
         r = (r >> 1) ^ (POLY_REFLECTED & {CRC_W{r[0]}});
      end
      return r;
   endfunction

   // Folds the low `count` bytes (saturated at eight) of a word, byte 0 first.
   function automatic crc_type fold_word(input crc_type rem, input data_type din,
                                         input count_type count);
      crc_type   r;
      count_type n;
      r = rem;
      n = (count > MAX_COUNT) ? MAX_COUNT : count;
      for (int i = 0; i < BYTES; i++) begin
         if (COUNT_W'(i) < n) begin
            r = fold_byte(r, din[8*i +: 8]);
         end
      end
      return r;
   endfunction

endpackage

### sv/crc32c_if.sv
// Interfaces: request and response channels of the CRC-32C engine.
`timescale 1ns / 1ps

interface crc32c_req_if;
   logic                  valid;
   logic                  ready;
   crc32c_pkg::data_type  data_word;
   crc32c_pkg::count_type byte_count;
   logic                  last_chunk;

   modport source (output valid, data_word, byte_count, last_chunk, input ready);
   modport sink   (input valid, data_word, byte_count, last_chunk, output ready);
endinterface

interface crc32c_rsp_if;
   logic                valid;
   logic                ready;
   crc32c_pkg::crc_type crc_value;

   modport source (output valid, crc_value, input ready);
   modport sink   (input valid, crc_value, output ready);
endinterface

### sv/crc32c_stream_engine_top.sv
// Top level: streaming CRC-32C (reflected, zero seed, no final inversion) engine.
`timescale 1ns / 1ps

// Usage
//   req (sink): one message chunk per request. data_word carries up to eight
//     bytes, byte 0 in bits 7:0; byte_count gives how many low bytes count
//     (0 folds nothing, above 8 is taken as 8); last_chunk closes the message.
//   rsp (source): one response per message, crc_value = CRC-32C of all bytes
//     since the previous last chunk (or reset), seed zero, no final XOR.
//   Throughput: one request per cycle, sustained, any mix of chunk sizes,
//     unless a last chunk waits on an unread response. The running
//     remainder loops through the eight-byte fold combinationally, so the
//     next chunk always sees the updated value.
//   Path: a last chunk passes the input register, then the result register.
//   Stall: while a response sits unread, non-last chunks keep flowing; a
//     last chunk waits in the input register and req.ready drops until the
//     result register frees up (same cycle as rsp.ready is high).
//   Reset (synchronous): empties both registers and zeroes the remainder.
module crc32c_stream_engine_top (
   input logic          clock,
   input logic          reset,
   crc32c_req_if.sink   req,
   crc32c_rsp_if.source rsp
);

   // Input register
   logic                  s1_valid_ff, s1_valid_in;
   crc32c_pkg::data_type  s1_data_ff;
   crc32c_pkg::count_type s1_count_ff;
   logic                  s1_last_ff;

   // Running remainder and result register
   crc32c_pkg::crc_type rem_ff, rem_in;
   logic                rsp_valid_ff, rsp_valid_in;
   crc32c_pkg::crc_type rsp_crc_ff;

   crc32c_pkg::crc_type fold_crc;
   logic                out_free;
   logic                s1_advance;
   logic                req_take;

   assign fold_crc   = crc32c_pkg::fold_word(rem_ff, s1_data_ff, s1_count_ff);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   // Non-last chunks produce nothing, so they never wait on the output side.
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req.valid && req.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         rem_in = s1_last_ff ? '0 : fold_crc;
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff  <= req.data_word;
         s1_count_ff <= req.byte_count;
         s1_last_ff  <= req.last_chunk;
      end
      if (s1_advance && s1_last_ff) begin
         rsp_crc_ff <= fold_crc;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.crc_value = rsp_crc_ff;

endmodule

### sv/crc32c_checker.sv
// Checker: port-level assertions for the CRC-32C engine, bound to the top level.
`timescale 1ns / 1ps

module crc32c_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input crc32c_pkg::crc_type rsp_crc
);

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_crc)))
      else $error("response changed while stalled");

   // With the result register empty, nothing can block a request.
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no response pending");

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind crc32c_stream_engine_top crc32c_checker u_crc32c_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_crc   (rsp.crc_value)
);

### tb/sv/tb_crc32c_stream_engine_top.sv
// Testbench: CRC-32C stream engine checked against a bitwise CRC predictor.
`timescale 1ns / 1ps

module tb_crc32c_stream_engine_top;

   localparam int RANDOM_CHUNKS = 1625;
   localparam int REPORT_LIMIT  = 10;

   // One directed request; typed_crc is used only when has_typed is set.
   typedef struct {
      crc32c_pkg::data_type  word;
      crc32c_pkg::count_type count;
      logic                  last;
      logic                  has_typed;
      crc32c_pkg::crc_type   typed_crc;
   } chunk_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   crc32c_req_if req_bus ();
   crc32c_rsp_if rsp_bus ();

   crc32c_stream_engine_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: remainder of the open message, and CRCs still owed.
   crc32c_pkg::crc_type running_crc = '0;
   crc32c_pkg::crc_type pending_crcs[$];
   int                  mismatch_count = 0;
   int                  chunks_sent    = 0;
   logic                calm_mode      = 1'b0;   // no idling on either side while set

   // Directed table: after-reset values, extremes, zero and oversized counts,
   // ignored upper bytes, multi-chunk messages.
   chunk_row_type directed_rows[] = '{
      // zero count closes an empty message right after reset
      '{64'h0,                  4'd0,  1'b1, 1'b1, 32'h0000_0000},
      '{64'h0,                  4'd1,  1'b1, 1'b1, 32'h0000_0000},
      // single 0x80 byte walks straight onto the polynomial
      '{64'h0000_0000_0000_0080, 4'd1,  1'b1, 1'b1, 32'h82F6_3B78},
      // byte 0x01 with junk above byte_count: junk must be ignored
      '{64'hFFFF_FFFF_FFFF_FF01, 4'd1,  1'b1, 1'b1, 32'hF26B_8303},
      '{64'h0,                  4'd8,  1'b1, 1'b1, 32'h0000_0000},
      // count above eight saturates; zeros still give zero
      '{64'h0,                  4'd15, 1'b1, 1'b1, 32'h0000_0000},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9,  1'b1, 1'b0, 32'h0},
      '{64'h8000_0000_0000_0000, 4'd8,  1'b1, 1'b0, 32'h0},
      // three-chunk message with a zero-count chunk in the middle
      '{64'h0123_4567_89AB_CDEF, 4'd9,  1'b0, 1'b0, 32'h0},
      '{64'hDEAD_BEEF_DEAD_BEEF, 4'd0,  1'b0, 1'b0, 32'h0},
      '{64'hA5A5_A5A5_A5A5_A5A5, 4'd3,  1'b1, 1'b0, 32'h0},
      // counts one through eight in one message
      '{64'h1111_1111_1111_1131, 4'd1,  1'b0, 1'b0, 32'h0},
      '{64'h2222_2222_2222_3232, 4'd2,  1'b0, 1'b0, 32'h0},
      '{64'h3333_3333_3334_3333, 4'd3,  1'b0, 1'b0, 32'h0},
      '{64'h4444_4444_5555_4444, 4'd4,  1'b0, 1'b0, 32'h0},
      '{64'h5555_5566_7788_9900, 4'd5,  1'b0, 1'b0, 32'h0},
      '{64'h6666_FEDC_BA98_7654, 4'd6,  1'b0, 1'b0, 32'h0},
      '{64'h77C3_3C00_FF12_3456, 4'd7,  1'b0, 1'b0, 32'h0},
      '{64'hF0E1_D2C3_B4A5_9687, 4'd8,  1'b0, 1'b0, 32'h0},
      // empty last chunk still emits the remainder, then clears it
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b0, 32'h0},
      '{64'h0,                  4'd0,  1'b1, 1'b1, 32'h0000_0000}
   };

   // Bit-serial reflected CRC over the low bytes of a word, LSB first.
   function automatic crc32c_pkg::crc_type crc_after_chunk(
         input crc32c_pkg::crc_type crc, input crc32c_pkg::data_type word,
         input crc32c_pkg::count_type count);
      int                  nbits;
      logic                feedback;
      crc32c_pkg::crc_type r;
      r     = crc;
      nbits = (count > 4'd8) ? 64 : 8 * int'(count);
      for (int k = 0; k < nbits; k++) begin
         feedback = r[0] ^ word[k];
         r        = r >> 1;
         if (feedback) r = r ^ crc32c_pkg::POLY_REFLECTED;
      end
      return r;
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (calm_mode || sel < 65) return 0;
      if (sel < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one request at the falling edge, holds it until accepted, then
   // updates the predictor. A typed CRC, when given, replaces the prediction.
   task automatic send_chunk(input crc32c_pkg::data_type word,
                             input crc32c_pkg::count_type count, input logic last,
                             input logic has_typed, input crc32c_pkg::crc_type typed_crc);
      int                  gap;
      crc32c_pkg::crc_type next_crc;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.data_word  <= word;
      req_bus.byte_count <= count;
      req_bus.last_chunk <= last;
      do @(posedge clock); while (!req_bus.ready);
      chunks_sent++;
      next_crc = crc_after_chunk(running_crc, word, count);
      if (last) begin
         pending_crcs.push_back(has_typed ? typed_crc : next_crc);
         running_crc = '0;
      end else begin
         running_crc = next_crc;
      end
   endtask

   function automatic crc32c_pkg::count_type pick_count();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 6) return '0;
      if (sel < 12) return crc32c_pkg::count_type'($urandom_range(9, 15));
      return crc32c_pkg::count_type'($urandom_range(1, 8));
   endfunction

   // Well-formed message with random content and length.
   task automatic send_random_message();
      int                   nchunks;
      int                   sel;
      crc32c_pkg::data_type word;
      sel = $urandom_range(0, 99);
      if (sel < 10) nchunks = 1;
      else if (sel < 85) nchunks = $urandom_range(2, 6);
      else nchunks = $urandom_range(7, 30);
      for (int c = 0; c < nchunks; c++) begin
         word = {$urandom, $urandom};
         send_chunk(word, pick_count(), c == nchunks - 1, 1'b0, '0);
      end
   endtask

   // Response side: ready changes at the falling edge, with random stalls.
   int stall_left = 0;
   always @(negedge clock) begin
      if (calm_mode) begin
         rsp_bus.ready <= 1'b1;
         stall_left    <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left    <= pick_gap();
      end
   end

   // Response check at the rising edge against the oldest owed CRC.
   always @(posedge clock) begin
      crc32c_pkg::crc_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_crcs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: crc_value %h", rsp_bus.crc_value);
         end else begin
            want = pending_crcs.pop_front();
            if (rsp_bus.crc_value !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("crc_value mismatch: expected %h got %h", want,
                           rsp_bus.crc_value);
            end
         end
      end
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.data_word  = '0;
      req_bus.byte_count = '0;
      req_bus.last_chunk = 1'b0;
      rsp_bus.ready      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_chunk(directed_rows[i].word, directed_rows[i].count, directed_rows[i].last,
                    directed_rows[i].has_typed, directed_rows[i].typed_crc);

      // Random messages; stretches with no idling come and go.
      while (chunks_sent < RANDOM_CHUNKS + directed_rows.size()) begin
         if ($urandom_range(0, 39) == 0) calm_mode = !calm_mode;
         send_random_message();
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;
      calm_mode = 1'b0;

      // Drain, then give the two-stage pipe time to show any stray response.
      while (pending_crcs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_crc32c_stream_engine_top OK");
      else
         $display("tb_crc32c_stream_engine_top NOT OK");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("tb_crc32c_stream_engine_top NOT OK");
      $finish;
   end

endmodule

### filelist.f
sv/crc32c_pkg.sv
sv/crc32c_if.sv
sv/crc32c_stream_engine_top.sv
sv/crc32c_checker.sv
tb/sv/tb_crc32c_stream_engine_top.sv
